// ===== sv/xadp_pkg.sv =====
// ----------------------------------------------------------------------------
// xadp_pkg
// Types and codes shared by the archive directory parser modules.
// ----------------------------------------------------------------------------
package xadp_pkg;

    localparam logic [7:0] KEY_RESET      = 8'hF7;
    localparam logic [7:0] TERMINATOR     = 8'h80;
    localparam logic [3:0] HEADER_BYTES   = 4'd8;
    localparam logic [3:0] SIZE_BYTES     = 4'd4;
    localparam logic [3:0] TIME_BYTES     = 4'd8;
    localparam logic [31:0] MIN_ARCHIVE   = 32'd16;

    // configuration register indexes
    localparam logic CFG_MAGIC = 1'b0;
    localparam logic CFG_KEY   = 1'b1;

    // parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_FLAG    = 3'd1;
    localparam logic [2:0] PH_NLEN    = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_SIZE    = 3'd4;
    localparam logic [2:0] PH_TIME    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    // field kinds
    localparam logic [2:0] FK_HEADER     = 3'd0;
    localparam logic [2:0] FK_FLAG       = 3'd1;
    localparam logic [2:0] FK_NAME_LEN   = 3'd2;
    localparam logic [2:0] FK_NAME       = 3'd3;
    localparam logic [2:0] FK_SIZE       = 3'd4;
    localparam logic [2:0] FK_TIME       = 3'd5;
    localparam logic [2:0] FK_TERMINATOR = 3'd6;
    localparam logic [2:0] FK_PAYLOAD    = 3'd7;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_MAGIC     = 3'd2;
    localparam logic [2:0] ERR_VERSION   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  byte_in_field;
        logic [7:0]  name_left;
        logic [31:0] size_acc;
        logic [63:0] time_acc;
        logic [31:0] offset_acc;
        logic [31:0] position;
        logic [2:0]  error;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [31:0] directory_end;
        logic [31:0] payload_offset;
        logic [63:0] entry_time;
        logic [31:0] entry_length;
        logic        entry_complete;
        logic [15:0] entry_number;
        logic [7:0]  decoded_byte;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

endpackage

// ===== sv/xadp_step.sv =====
// ----------------------------------------------------------------------------
// xadp_step
// Next-state and result logic for one archive byte.
// ----------------------------------------------------------------------------
module xadp_step import xadp_pkg::*; #(
    parameter int ENTRY_INDEX_BITS = 16
) (
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_stream,
    input  logic [31:0]                 magic_word,
    input  logic [7:0]                  xor_key,
    input  parse_state_t                st,
    input  logic [ENTRY_INDEX_BITS-1:0] entry_count,
    output parse_state_t                st_next,
    output logic [ENTRY_INDEX_BITS-1:0] entry_count_next,
    output result_t                     res,
    output logic [2:0]                  field_kind
);

    always_comb begin
        logic [7:0]  d;
        logic [3:0]  b;
        logic [3:0]  b_inc;
        logic [2:0]  kind;
        logic        complete;
        logic [31:0] dirend;
        logic [2:0]  err;
        parse_state_t ns;
        logic [ENTRY_INDEX_BITS-1:0] cnt;

        d        = data_byte ^ xor_key;
        b        = st.byte_in_field;
        b_inc    = b + 4'd1;
        kind     = FK_PAYLOAD;
        complete = 1'b0;
        dirend   = '0;
        err      = st.error;
        ns       = st;
        cnt      = entry_count;

        unique case (st.phase)
            PH_HEADER: begin
                kind = FK_HEADER;
                if (b < 4'd4 && d != magic_word[{b[1:0], 3'b000} +: 8] && err == ERR_NONE)
                    err = ERR_MAGIC;
                if (b == 4'd4 && d != 8'd0 && err == ERR_NONE)
                    err = ERR_VERSION;
                ns.byte_in_field = b_inc;
                if (b_inc >= HEADER_BYTES) begin
                    ns.phase         = PH_FLAG;
                    ns.byte_in_field = '0;
                end
            end
            PH_FLAG: begin
                if (d == TERMINATOR) begin
                    kind     = FK_TERMINATOR;
                    dirend   = st.position + 32'd1;
                    ns.phase = PH_PAYLOAD;
                end else begin
                    kind        = FK_FLAG;
                    ns.size_acc = '0;
                    ns.time_acc = '0;
                    ns.phase    = PH_NLEN;
                end
                ns.byte_in_field = '0;
            end
            PH_NLEN: begin
                kind             = FK_NAME_LEN;
                ns.name_left     = d;
                ns.phase         = (d != 8'd0) ? PH_NAME : PH_SIZE;
                ns.byte_in_field = '0;
            end
            PH_NAME: begin
                kind         = FK_NAME;
                ns.name_left = st.name_left - 8'd1;
                if (ns.name_left == 8'd0) begin
                    ns.phase         = PH_SIZE;
                    ns.byte_in_field = '0;
                end
            end
            PH_SIZE: begin
                kind             = FK_SIZE;
                ns.size_acc      = st.size_acc | ({24'd0, d} << {b[1:0], 3'b000});
                ns.byte_in_field = b_inc;
                if (b_inc >= SIZE_BYTES) begin
                    ns.phase         = PH_TIME;
                    ns.byte_in_field = '0;
                end
            end
            PH_TIME: begin
                kind             = FK_TIME;
                ns.time_acc      = st.time_acc | ({56'd0, d} << {b[2:0], 3'b000});
                ns.byte_in_field = b_inc;
                if (b_inc >= TIME_BYTES) begin
                    complete         = 1'b1;
                    ns.offset_acc    = st.offset_acc + st.size_acc;
                    cnt              = entry_count + ENTRY_INDEX_BITS'(1);
                    ns.phase         = PH_FLAG;
                    ns.byte_in_field = '0;
                end
            end
            default: begin
                kind = FK_PAYLOAD;
            end
        endcase

        if (end_of_stream) begin
            if (st.position < MIN_ARCHIVE - 32'd1)
                err = ERR_SHORT;
            else if (ns.phase != PH_PAYLOAD && kind != FK_TERMINATOR && err == ERR_NONE)
                err = ERR_TRUNCATED;
        end
        ns.error = err;

        res.decoded_byte   = d;
        res.entry_number   = 16'(entry_count);
        res.entry_complete = complete;
        res.entry_length   = ns.size_acc;
        res.entry_time     = ns.time_acc;
        res.payload_offset = st.offset_acc;
        res.directory_end  = dirend;
        res.error_code     = err;
        field_kind         = kind;

        if (st.position != 32'hFFFF_FFFF)
            ns.position = st.position + 32'd1;

        if (end_of_stream) begin
            ns  = '0;
            cnt = '0;
        end

        st_next          = ns;
        entry_count_next = cnt;
    end

endmodule

// ===== sv/xor_archive_directory_parser_unit.sv =====
// ----------------------------------------------------------------------------
// xor_archive_directory_parser_unit
// Decodes an XOR-coded archive byte stream and parses its directory entries.
// ----------------------------------------------------------------------------
// An accepted byte's result is registered and appears on the m_ side in the next cycle.
// Throughput: 1 byte per cycle; a byte is taken in the cycle its predecessor's
// result leaves, and s_tready drops while a result waits unaccepted.
// Reset (aresetn low, synchronous): parse state cleared, no result held,
// magic_word = 0, xor_key = 0xF7. A byte with s_tlast also clears parse state.
module xor_archive_directory_parser_unit import xadp_pkg::*; #(
    parameter int ENTRY_INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // data_byte
    input  logic                  s_tlast,    // end_of_stream

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // decoded_byte[7:0], entry_number[23:8], entry_complete[24],
    // entry_length[56:25], entry_time[120:57], payload_offset[152:121],
    // directory_end[184:153], error_code[187:185], zero fill
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic [2:0]            m_tuser,    // field_kind
    output logic                  m_tlast,    // last_result

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    logic [31:0] magic_reg;
    logic [7:0]  key_reg;

    parse_state_t                st_reg, st_next;
    logic [ENTRY_INDEX_BITS-1:0] count_reg, count_next;

    result_t     res;
    logic [2:0]  kind;
    result_t     res_reg;
    logic [2:0]  kind_reg;
    logic        last_reg;
    logic        valid_reg;

    logic        s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= '0;
            key_reg   <= KEY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAGIC: magic_reg <= cfg_data;
                CFG_KEY:   key_reg   <= cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    xadp_step #(
        .ENTRY_INDEX_BITS (ENTRY_INDEX_BITS)
    ) u_step (
        .data_byte        (s_tdata),
        .end_of_stream    (s_tlast),
        .magic_word       (magic_reg),
        .xor_key          (key_reg),
        .st               (st_reg),
        .entry_count      (count_reg),
        .st_next          (st_next),
        .entry_count_next (count_next),
        .res              (res),
        .field_kind       (kind)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                st_reg    <= st_next;
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg  <= res;
            kind_reg <= kind;
            last_reg <= s_tlast;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_BITS'(res_reg);
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_dirend_on_terminator: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.directory_end != 32'd0) |-> (kind_reg == FK_TERMINATOR))
        else $error("directory end reported off the terminator");

    a_complete_on_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.entry_complete) |-> (kind_reg == FK_TIME))
        else $error("entry complete outside timestamp field");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (st_reg.phase == PH_HEADER && st_reg.position == 32'd0))
        else $error("parse state not cleared after last item");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && st_reg.phase == PH_PAYLOAD && !s_tlast) |=> (st_reg.phase == PH_PAYLOAD))
        else $error("left payload phase before end of stream");
`endif

endmodule
